// File: hw/rtl/xs64rng_pkg.sv
package xs64rng_pkg;

   localparam int unsigned StateWidth = 64;
   localparam int unsigned WordWidth  = 32;
   localparam int unsigned DivSteps   = 32;
   localparam int unsigned DivCntWidth = $clog2(DivSteps);

   localparam logic [StateWidth-1:0] RngMult    = 64'h2545_F491_4F6C_DD1D;
   localparam logic [StateWidth-1:0] RngDefault = 64'hCAFE_BABE_1234_5678;

   localparam int unsigned ShiftA = 12;
   localparam int unsigned ShiftB = 25;
   localparam int unsigned ShiftC = 27;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_MUL,
      S_DIV,
      S_LOAD
   } state_type;

   // partial products of the low 64 bits of state * multiplier
   typedef enum logic [1:0] {
      MUL_LL,
      MUL_LH,
      MUL_HL
   } mul_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        prep;
      logic        advance;
      logic        mul_step;
      mul_sel_type mul_sel;
      logic        div_step;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      logic func;
      logic empty;
   } stat_type;

   function automatic logic [StateWidth-1:0] xorshift(input logic [StateWidth-1:0] s);
      logic [StateWidth-1:0] x;
      x = s;
      x = x ^ (x >> ShiftA);
      x = x ^ (x << ShiftB);
      x = x ^ (x >> ShiftC);
      return x;
   endfunction

endpackage

// File: hw/rtl/xorshift64_star_range_rng.sv
// xorshift64* generator with an optional ranged output. Each request word
// returns one result word. A raw request (func 0) goes through one xorshift
// step, three passes through the shared 32x32 multiplier and one output load.
// A ranged request with a non-empty range adds the bit-serial restoring
// divider that forms draw mod span. An empty range (high not above low) goes
// straight to the output load and leaves the state alone. A result still
// waiting in the output register holds the load; the next request is taken
// the cycle after the previous one has moved into the output register.
// Writing the seed reloads the state at once (zero loads the built-in
// default); write it only while the block is idle.
module xorshift64_star_range_rng (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [63:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic signed [31:0] req_range_low,
   input  logic signed [31:0] req_range_high,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_raw_draw,
   output logic signed [31:0] rsp_ranged_value,
   output logic               rsp_advanced
);
   import xs64rng_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   xs64rng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   xs64rng_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_func         (req_func),
      .req_range_low    (req_range_low),
      .req_range_high   (req_range_high),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_raw_draw     (rsp_raw_draw),
      .rsp_ranged_value (rsp_ranged_value),
      .rsp_advanced     (rsp_advanced)
   );

endmodule

// File: hw/rtl/xs64rng_ctrl.sv
module xs64rng_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  xs64rng_pkg::stat_type stat,
   output xs64rng_pkg::cmd_type  cmd
);
   import xs64rng_pkg::*;

   state_type               state_ff, state_in;
   mul_sel_type             mul_sel_ff, mul_sel_in;
   logic [DivCntWidth-1:0]  div_cnt_ff, div_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mul_sel_ff   <= MUL_LL;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mul_sel_ff   <= mul_sel_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      mul_sel_in = mul_sel_ff;
      div_cnt_in = div_cnt_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.mul_sel = mul_sel_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_SHIFT;
            end
         end
         S_SHIFT: begin
            cmd.prep    = 1'b1;
            cmd.advance = !stat.empty;
            mul_sel_in  = MUL_LL;
            state_in    = stat.empty ? S_LOAD : S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            case (mul_sel_ff)
               MUL_LL: mul_sel_in = MUL_LH;
               MUL_LH: mul_sel_in = MUL_HL;
               default: begin
                  div_cnt_in = '0;
                  state_in   = stat.func ? S_DIV : S_LOAD;
               end
            endcase
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DivCntWidth'(DivSteps - 1)) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_to_shift: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_SHIFT))
      else $error("accepted word did not start the step");

   a_empty_skips: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && stat.empty) |=> (state_ff == S_LOAD))
      else $error("empty range did not skip to load");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && div_cnt_ff == DivCntWidth'(DivSteps - 1))
         |=> (state_ff == S_LOAD))
      else $error("divider did not finish after its last step");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

// File: hw/rtl/xs64rng_dp.sv
module xs64rng_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [63:0]         csr_wr_data,
   input  logic                req_func,
   input  logic signed [31:0]  req_range_low,
   input  logic signed [31:0]  req_range_high,
   input  xs64rng_pkg::cmd_type cmd,
   output xs64rng_pkg::stat_type stat,
   output logic [31:0]         rsp_raw_draw,
   output logic signed [31:0]  rsp_ranged_value,
   output logic                rsp_advanced
);
   import xs64rng_pkg::*;

   logic [StateWidth-1:0]  gen_ff;
   logic                   func_ff;
   logic [WordWidth-1:0]   lo_ff, hi_ff;
   logic [WordWidth-1:0]   span_ff, rem_ff, dvd_ff, acc_ff, draw_ff;
   logic [WordWidth-1:0]   raw_ff, ranged_ff;
   logic                   adv_ff;

   logic                   empty;
   logic [WordWidth-1:0]   mul_a, mul_b, acc_sum;
   logic [2*WordWidth-1:0] prod;
   logic [WordWidth:0]     trial, diff;

   assign empty = func_ff && ($signed(hi_ff) <= $signed(lo_ff));
   assign stat  = '{func: func_ff, empty: empty};

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= RngDefault;
      end else if (csr_wr_en) begin
         gen_ff <= (csr_wr_data != '0) ? csr_wr_data : RngDefault;
      end else if (cmd.advance) begin
         gen_ff <= xorshift(gen_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_func;
         lo_ff   <= req_range_low;
         hi_ff   <= req_range_high;
      end
      if (cmd.prep) begin
         span_ff <= hi_ff - lo_ff;
      end
   end

   // one shared 32x32 multiplier; only the low 64 bits of the product matter
   always_comb begin
      case (cmd.mul_sel)
         MUL_LL: begin
            mul_a = gen_ff[WordWidth-1:0];
            mul_b = RngMult[WordWidth-1:0];
         end
         MUL_LH: begin
            mul_a = gen_ff[WordWidth-1:0];
            mul_b = RngMult[StateWidth-1:WordWidth];
         end
         default: begin
            mul_a = gen_ff[StateWidth-1:WordWidth];
            mul_b = RngMult[WordWidth-1:0];
         end
      endcase
   end

   assign prod    = mul_a * mul_b;
   assign acc_sum = acc_ff + prod[WordWidth-1:0];

   assign trial = {rem_ff, dvd_ff[WordWidth-1]};
   assign diff  = trial - {1'b0, span_ff};

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         rem_ff <= '0;
      end
      if (cmd.mul_step) begin
         case (cmd.mul_sel)
            MUL_LL: acc_ff <= prod[2*WordWidth-1:WordWidth];
            MUL_LH: acc_ff <= acc_sum;
            default: begin
               draw_ff <= acc_sum;
               dvd_ff  <= acc_sum;
            end
         endcase
      end
      if (cmd.div_step) begin
         // restoring step: keep the difference unless it went negative
         rem_ff <= diff[WordWidth] ? trial[WordWidth-1:0] : diff[WordWidth-1:0];
         dvd_ff <= {dvd_ff[WordWidth-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         raw_ff <= empty ? '0 : draw_ff;
         if (!func_ff) begin
            ranged_ff <= '0;
         end else if (empty) begin
            ranged_ff <= lo_ff;
         end else begin
            ranged_ff <= lo_ff + rem_ff;
         end
         adv_ff <= !empty;
      end
   end

   assign rsp_raw_draw     = raw_ff;
   assign rsp_ranged_value = ranged_ff;
   assign rsp_advanced     = adv_ff;

endmodule

// File: test/xorshift64_star_range_rng_test.sv
module xorshift64_star_range_rng_test;

   localparam logic FUNC_RAW    = 1'b0;
   localparam logic FUNC_RANGED = 1'b1;

   localparam logic [63:0] STAR_MULT    = 64'h2545_F491_4F6C_DD1D;
   localparam logic [63:0] ZERO_SEED_SUB = 64'hCAFE_BABE_1234_5678;

   localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned MAX_REPORTS = 10;

   typedef struct packed {
      logic               func;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
   } draw_req_type;

   typedef struct packed {
      logic [31:0]        raw;
      logic signed [31:0] ranged;
      logic               adv;
   } draw_rsp_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [63:0]        csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_func = FUNC_RAW;
   logic signed [31:0] req_range_low = '0;
   logic signed [31:0] req_range_high = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [31:0]        rsp_raw_draw;
   logic signed [31:0] rsp_ranged_value;
   logic               rsp_advanced;

   draw_req_type pending_reqs[$];
   draw_rsp_type expected_draws[$];
   logic [63:0]  gen_state = ZERO_SEED_SUB;
   int unsigned  send_idle_pct = 24;
   int unsigned  recv_idle_pct = 78;
   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count = 0;

   xorshift64_star_range_rng u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_range_low    (req_range_low),
      .req_range_high   (req_range_high),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_raw_draw     (rsp_raw_draw),
      .rsp_ranged_value (rsp_ranged_value),
      .rsp_advanced     (rsp_advanced)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Step the generator when the word draws and form the expected result.
   function automatic draw_rsp_type next_draw(draw_req_type r);
      draw_rsp_type d;
      logic [63:0]  x;
      logic [63:0]  prod;
      logic [31:0]  span;
      d = '0;
      if (r.func == FUNC_RAW || r.hi > r.lo) begin
         x = gen_state;
         x = x ^ (x >> 12);
         x = x ^ (x << 25);
         x = x ^ (x >> 27);
         gen_state = x;
         prod = x * STAR_MULT;
         d.raw = prod[63:32];
         d.adv = 1'b1;
         if (r.func == FUNC_RANGED) begin
            span = r.hi - r.lo;
            d.ranged = r.lo + (d.raw % span);
         end
      end else begin
         d.ranged = r.lo;
      end
      return d;
   endfunction

   function automatic draw_req_type random_request();
      draw_req_type r;
      int unsigned  pick;
      logic [31:0]  span;
      longint       top;
      r.func = 1'($urandom_range(0, 1));
      r.lo = $urandom;
      r.hi = $urandom;
      pick = $urandom_range(0, 9);
      if (r.func == FUNC_RANGED && pick >= 2) begin
         if (pick == 2) begin
            // empty range, sometimes with equal bounds
            if (r.hi > r.lo) r.hi = r.lo;
         end else begin
            if (pick <= 5) span = $urandom_range(1, 64);
            else if (pick <= 7) span = $urandom_range(1, 32'h00FF_FFFF);
            else span = 32'd1 << $urandom_range(0, 31);
            top = longint'(r.lo) + longint'(span);
            if (top > longint'(INT_MAX)) r.lo = r.lo - span;
            r.hi = r.lo + span;
         end
      end
      return r;
   endfunction

   task automatic add_req(logic func, logic signed [31:0] lo, logic signed [31:0] hi);
      draw_req_type r;
      r.func = func;
      r.lo = lo;
      r.hi = hi;
      pending_reqs.push_back(r);
   endtask

   task automatic add_random(int unsigned n);
      @(negedge clock);
      repeat (n) pending_reqs.push_back(random_request());
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || expected_draws.size() != 0 || req_valid);
   endtask

   task automatic write_seed(logic [63:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      gen_state = (value != 64'd0) ? value : ZERO_SEED_SUB;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Driver: present queued words, hold each until accepted.
   always @(posedge clock) begin
      draw_req_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            r.func = req_func;
            r.lo = req_range_low;
            r.hi = req_range_high;
            expected_draws.push_back(next_draw(r));
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               r = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_func <= r.func;
               req_range_low <= r.lo;
               req_range_high <= r.hi;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted word with the oldest expectation.
   always @(posedge clock) begin
      draw_rsp_type d;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_draws.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < MAX_REPORTS)
                  $display("unexpected word: raw %h ranged %0d advanced %0b",
                           rsp_raw_draw, rsp_ranged_value, rsp_advanced);
            end else begin
               d = expected_draws.pop_front();
               if (rsp_raw_draw !== d.raw || rsp_ranged_value !== d.ranged ||
                   rsp_advanced !== d.adv) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < MAX_REPORTS)
                     $display("mismatch: raw %h/%h ranged %0d/%0d advanced %0b/%0b (exp/act)",
                              d.raw, rsp_raw_draw, d.ranged, rsp_ranged_value,
                              d.adv, rsp_advanced);
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("xorshift64_star_range_rng_test NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed words against the reset state
      @(negedge clock);
      add_req(FUNC_RAW, INT_MIN, INT_MAX);
      add_req(FUNC_RAW, INT_MAX, INT_MIN);
      add_req(FUNC_RAW, -1, -1);
      add_req(FUNC_RAW, 0, 0);
      add_req(FUNC_RANGED, 0, 1);
      add_req(FUNC_RANGED, INT_MIN, INT_MAX);
      add_req(FUNC_RANGED, -1, 0);
      add_req(FUNC_RANGED, INT_MAX, INT_MIN);
      add_req(FUNC_RANGED, 0, 0);
      add_req(FUNC_RANGED, INT_MIN, INT_MIN);
      add_req(FUNC_RANGED, INT_MAX, INT_MAX);
      add_req(FUNC_RANGED, 5, 4);
      add_req(FUNC_RANGED, -100, 100);
      add_req(FUNC_RANGED, INT_MAX - 1, INT_MAX);
      add_req(FUNC_RANGED, INT_MIN, INT_MIN + 1);
      add_req(FUNC_RANGED, 0, INT_MAX);
      add_req(FUNC_RANGED, INT_MIN, 0);
      add_req(FUNC_RANGED, -7, -4);
      add_req(FUNC_RANGED, 0, 32'sh0001_0000);
      add_req(FUNC_RANGED, -1, INT_MAX);
      add_req(FUNC_RANGED, 0, -1);
      add_req(FUNC_RAW, 32'sh5555_5555, 32'shAAAA_AAAA);
      wait_idle();

      write_seed(64'hFFFF_FFFF_FFFF_FFFF);
      add_random(430);
      wait_idle();

      send_idle_pct = 78;
      recv_idle_pct = 24;
      write_seed(64'd1);
      add_random(430);
      wait_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_seed({$urandom, $urandom});
      add_random(215);
      // hold off until the block drains, then resume with no write
      wait_idle();
      add_random(215);
      wait_idle();

      write_seed(64'd0);
      add_random(430);
      wait_idle();

      repeat (48) @(posedge clock);
      if (mismatch_count == 0 && expected_draws.size() == 0)
         $display("xorshift64_star_range_rng_test OK");
      else
         $display("xorshift64_star_range_rng_test NOT OK");
      $finish;
   end

endmodule
